[hw/rtl/ean13_pkg.sv]
`default_nettype none

package ean13_pkg;

    localparam int unsigned NUM_CHARS  = 12;
    localparam int unsigned SEG_W      = 5;
    localparam int unsigned SUM_W      = 8;

    // Segment positions within one symbol.
    localparam logic [SEG_W-1:0] SEG_LEAD_QUIET  = 5'd0;
    localparam logic [SEG_W-1:0] SEG_LEAD_GUARD  = 5'd1;
    localparam logic [SEG_W-1:0] SEG_LEFT_FIRST  = 5'd2;
    localparam logic [SEG_W-1:0] SEG_LEFT_2      = 5'd3;
    localparam logic [SEG_W-1:0] SEG_LEFT_3      = 5'd4;
    localparam logic [SEG_W-1:0] SEG_LEFT_4      = 5'd5;
    localparam logic [SEG_W-1:0] SEG_LEFT_5      = 5'd6;
    localparam logic [SEG_W-1:0] SEG_LEFT_6      = 5'd7;
    localparam logic [SEG_W-1:0] SEG_CENTER      = 5'd8;
    localparam logic [SEG_W-1:0] SEG_RIGHT_7     = 5'd9;
    localparam logic [SEG_W-1:0] SEG_RIGHT_8     = 5'd10;
    localparam logic [SEG_W-1:0] SEG_RIGHT_9     = 5'd11;
    localparam logic [SEG_W-1:0] SEG_RIGHT_10    = 5'd12;
    localparam logic [SEG_W-1:0] SEG_RIGHT_11    = 5'd13;
    localparam logic [SEG_W-1:0] SEG_CHECK       = 5'd14;
    localparam logic [SEG_W-1:0] SEG_TRAIL_GUARD = 5'd15;
    localparam logic [SEG_W-1:0] SEG_TRAIL_QUIET = 5'd16;

    localparam logic [3:0] QUIET_MODULES = 4'd9;
    localparam logic [3:0] GUARD_COUNT   = 4'd3;
    localparam logic [3:0] CENTER_COUNT  = 4'd5;
    localparam logic [3:0] DIGIT_COUNT   = 4'd7;
    localparam logic [3:0] BAD_COUNT     = 4'd0;

    localparam logic [8:0] GUARD_BITS    = 9'h005;
    localparam logic [8:0] CENTER_BITS   = 9'h00A;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;

    // Queue entry: classified input item.
    typedef struct packed {
        logic [NUM_CHARS-1:0][3:0] digit;
        logic [SUM_W-1:0]          sum;
        logic                      bad;
    } entry_t;

    // Handshake group between the queue and the back end.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_out_t;

    function automatic logic [6:0] code_l(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'd0:    c = 7'h0D;
            4'd1:    c = 7'h19;
            4'd2:    c = 7'h13;
            4'd3:    c = 7'h3D;
            4'd4:    c = 7'h23;
            4'd5:    c = 7'h31;
            4'd6:    c = 7'h2F;
            4'd7:    c = 7'h3B;
            4'd8:    c = 7'h37;
            4'd9:    c = 7'h0B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] code_g(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'd0:    c = 7'h27;
            4'd1:    c = 7'h33;
            4'd2:    c = 7'h1B;
            4'd3:    c = 7'h21;
            4'd4:    c = 7'h1D;
            4'd5:    c = 7'h39;
            4'd6:    c = 7'h05;
            4'd7:    c = 7'h11;
            4'd8:    c = 7'h09;
            4'd9:    c = 7'h17;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] code_r(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'd0:    c = 7'h72;
            4'd1:    c = 7'h66;
            4'd2:    c = 7'h6C;
            4'd3:    c = 7'h42;
            4'd4:    c = 7'h5C;
            4'd5:    c = 7'h4E;
            4'd6:    c = 7'h50;
            4'd7:    c = 7'h44;
            4'd8:    c = 7'h48;
            4'd9:    c = 7'h74;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // bit 4 = character 2 ... bit 0 = character 6; 1 picks the G code
    function automatic logic [4:0] even_mask(input logic [3:0] d);
        logic [4:0] m;
        case (d)
            4'd0:    m = 5'h00;
            4'd1:    m = 5'h0B;
            4'd2:    m = 5'h0D;
            4'd3:    m = 5'h0E;
            4'd4:    m = 5'h13;
            4'd5:    m = 5'h19;
            4'd6:    m = 5'h1C;
            4'd7:    m = 5'h15;
            4'd8:    m = 5'h16;
            4'd9:    m = 5'h1A;
            default: m = 5'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ean13_front.sv]
`default_nettype none

module ean13_front (
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [47:0]       digits_high,
    input  wire logic [47:0]       digits_low,
    input  wire logic              q_full,
    output logic                   q_push,
    output ean13_pkg::entry_t      q_entry
);
    import ean13_pkg::*;

    logic [NUM_CHARS-1:0][7:0] ch;
    logic [NUM_CHARS-1:0][3:0] digit;
    logic [NUM_CHARS-1:0]      not_digit;
    logic [5:0]                sum_even;
    logic [5:0]                sum_odd;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ch[i]     = digits_high[47 - 8*i -: 8];
            ch[i + 6] = digits_low[47 - 8*i -: 8];
        end
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            not_digit[i] = (ch[i] < ASCII_ZERO) || (ch[i] > ASCII_NINE);
            // '0'..'9' carry the digit value in the low nibble
            digit[i]     = ch[i][3:0];
        end
    end

    // weight 1 on even positions, weight 3 on odd ones
    assign sum_even = 6'(digit[0]) + 6'(digit[2]) + 6'(digit[4])
                    + 6'(digit[6]) + 6'(digit[8]) + 6'(digit[10]);
    assign sum_odd  = 6'(digit[1]) + 6'(digit[3]) + 6'(digit[5])
                    + 6'(digit[7]) + 6'(digit[9]) + 6'(digit[11]);

    assign q_entry.digit = digit;
    assign q_entry.sum   = SUM_W'(sum_even) + SUM_W'(sum_odd) + {1'b0, sum_odd, 1'b0};
    assign q_entry.bad   = |not_digit;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

[hw/rtl/ean13_fifo.sv]
`default_nettype none

// Two-entry queue between front and back.
module ean13_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ean13_pkg::entry_t  push_entry,
    output logic                    full,
    input  wire logic               pop,
    output ean13_pkg::q_out_t       q_out
);
    import ean13_pkg::*;

    entry_t     mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full        = (count_reg == 2'd2);
    assign do_pop      = pop && (count_reg != 2'd0);
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ean13_back.sv]
`default_nettype none

// Segment sequencer: one segment per cycle, while out_ready allows, into a registered output.
module ean13_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ean13_pkg::q_out_t  q_out,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [8:0]              out_modules,
    output logic [3:0]              out_count,
    output logic                    out_bad,
    output logic                    out_last
);
    import ean13_pkg::*;

    typedef struct packed {
        logic [NUM_CHARS-1:0][3:0] digit;
        logic [3:0]                check;
        logic [4:0]                pmask;
        logic                      bad;
    } item_t;

    item_t            item_reg;
    item_t            item_next;
    logic             active_reg;
    logic             active_next;
    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] seg_next;

    logic             valid_reg;
    logic             valid_next;
    logic [8:0]       modules_reg;
    logic [8:0]       modules_next;
    logic [3:0]       count_reg;
    logic [3:0]       count_next;
    logic             bad_reg;
    logic             bad_next;
    logic             last_reg;
    logic             last_next;

    logic             advance;
    logic             last_now;
    logic [15:0]      recip;
    logic [4:0]       quot;
    logic [7:0]       rem8;
    logic [3:0]       rem;
    logic [8:0]       seg_bits;
    logic [3:0]       seg_count;

    // sum mod 10 by reciprocal: floor(s*205/2048) is exact for s < 1029
    assign recip = 16'(q_out.entry.sum) * 16'd205;
    assign quot  = recip[15:11];
    assign rem8  = q_out.entry.sum - 8'(quot) * 8'd10;
    assign rem   = rem8[3:0];

    assign advance  = !valid_reg || out_ready;
    assign last_now = item_reg.bad || (seg_reg == SEG_TRAIL_QUIET);
    assign q_pop    = !active_reg || (advance && last_now);

    always_comb
    begin
        seg_bits  = 9'h000;
        seg_count = DIGIT_COUNT;
        case (seg_reg)
            SEG_LEAD_QUIET:
            begin
                seg_bits  = 9'h000;
                seg_count = QUIET_MODULES;
            end
            SEG_LEAD_GUARD, SEG_TRAIL_GUARD:
            begin
                seg_bits  = GUARD_BITS;
                seg_count = GUARD_COUNT;
            end
            SEG_LEFT_FIRST: seg_bits = {2'b00, code_l(item_reg.digit[1])};
            SEG_LEFT_2: seg_bits = {2'b00, item_reg.pmask[4] ? code_g(item_reg.digit[2])
                                                              : code_l(item_reg.digit[2])};
            SEG_LEFT_3: seg_bits = {2'b00, item_reg.pmask[3] ? code_g(item_reg.digit[3])
                                                              : code_l(item_reg.digit[3])};
            SEG_LEFT_4: seg_bits = {2'b00, item_reg.pmask[2] ? code_g(item_reg.digit[4])
                                                              : code_l(item_reg.digit[4])};
            SEG_LEFT_5: seg_bits = {2'b00, item_reg.pmask[1] ? code_g(item_reg.digit[5])
                                                              : code_l(item_reg.digit[5])};
            SEG_LEFT_6: seg_bits = {2'b00, item_reg.pmask[0] ? code_g(item_reg.digit[6])
                                                              : code_l(item_reg.digit[6])};
            SEG_CENTER:
            begin
                seg_bits  = CENTER_BITS;
                seg_count = CENTER_COUNT;
            end
            SEG_RIGHT_7:  seg_bits = {2'b00, code_r(item_reg.digit[7])};
            SEG_RIGHT_8:  seg_bits = {2'b00, code_r(item_reg.digit[8])};
            SEG_RIGHT_9:  seg_bits = {2'b00, code_r(item_reg.digit[9])};
            SEG_RIGHT_10: seg_bits = {2'b00, code_r(item_reg.digit[10])};
            SEG_RIGHT_11: seg_bits = {2'b00, code_r(item_reg.digit[11])};
            SEG_CHECK:    seg_bits = {2'b00, code_r(item_reg.check)};
            SEG_TRAIL_QUIET:
            begin
                seg_bits  = 9'h000;
                seg_count = QUIET_MODULES;
            end
            default:
            begin
                seg_bits  = 9'h000;
                seg_count = BAD_COUNT;
            end
        endcase
    end

    always_comb
    begin
        item_next    = item_reg;
        active_next  = active_reg;
        seg_next     = seg_reg;
        valid_next   = valid_reg;
        modules_next = modules_reg;
        count_next   = count_reg;
        bad_next     = bad_reg;
        last_next    = last_reg;

        if (advance)
        begin
            valid_next = active_reg;
            if (active_reg)
            begin
                if (item_reg.bad)
                begin
                    modules_next = 9'h000;
                    count_next   = BAD_COUNT;
                end
                else
                begin
                    modules_next = seg_bits;
                    count_next   = seg_count;
                end
                bad_next    = item_reg.bad;
                last_next   = last_now;
                seg_next    = seg_reg + 5'd1;
                active_next = !last_now;
            end
        end

        if (q_pop && q_out.valid)
        begin
            item_next.digit = q_out.entry.digit;
            item_next.check = (rem == 4'd0) ? 4'd0 : 4'd10 - rem;
            item_next.pmask = even_mask(q_out.entry.digit[0]);
            item_next.bad   = q_out.entry.bad;
            active_next     = 1'b1;
            seg_next        = SEG_LEAD_QUIET;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        modules_reg <= modules_next;
        count_reg   <= count_next;
        bad_reg     <= bad_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            seg_reg    <= SEG_LEAD_QUIET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            seg_reg    <= seg_next;
            valid_reg  <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_modules = modules_reg;
    assign out_count   = count_reg;
    assign out_bad     = bad_reg;
    assign out_last    = last_reg;

endmodule

`default_nettype wire

[hw/rtl/ean13_barcode_module_encoder_top.sv]
`default_nettype none

// Channel   Dir  Signals                          Contents
// s_axis    in   s_tvalid s_tready s_tdata[95:0]  twelve ASCII characters
// m_axis    out  m_tvalid m_tready m_tdata[15:0]  one bar segment per transfer
//                m_tuser m_tlast                  bad input flag, last segment
//
// A valid code gives 17 output transfers, one per cycle while m_tready stays
// high; the back-end sequencer sets the input rate, as it loads a code only with
// the last segment of the one before. A code with a non-digit character gives one
// transfer. The first output passes queue write, sequencer load and output register.
// Reset (rst_n low, asynchronous) empties the queue and the output register.
// m_axis back-pressure stalls the sequencer; inputs are taken until the queue is full.

module ean13_barcode_module_encoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [47:0] digits_high, [95:48] digits_low
    input  wire logic [95:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [8:0] modules, [12:9] module_count, [15:13] zero
    output logic [15:0]      m_tdata,
    // [0] bad_input
    output logic             m_tuser,
    output logic             m_tlast
);
    import ean13_pkg::*;

    logic       q_full;
    logic       q_push;
    entry_t     q_entry;
    logic       q_pop;
    q_out_t     q_out;
    logic [8:0] seg_modules;
    logic [3:0] seg_count;

    // Front: checks the characters, extracts digits, forms the weighted sum.
    ean13_front u_front (
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .digits_high (s_tdata[47:0]),
        .digits_low  (s_tdata[95:48]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    // Queue decouples input acceptance from segment output.
    ean13_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_out      (q_out)
    );

    // Back: finishes the check digit and walks the 17 segments of a valid code.
    ean13_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_out       (q_out),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_modules (seg_modules),
        .out_count   (seg_count),
        .out_bad     (m_tuser),
        .out_last    (m_tlast)
    );

    assign m_tdata = {3'b000, seg_count, seg_modules};

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

// EAN-13 module encoder testbench.
// A stimulus block fills a queue of codes, a falling-edge driver presents them
// on the slave stream, and the segments on the master stream are checked,
// field by field, against a symbol encoder written here.

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET = 9;        // quiet zone width, in modules
    localparam int MAX_WAIT = 17;    // longest random gap or stall

    // Segment shape constants
    localparam logic [8:0] GUARD_MODS  = 9'h005;  // 101
    localparam logic [8:0] CENTER_MODS = 9'h00A;  // 01010
    localparam logic [3:0] GUARD_LEN   = 4'd3;
    localparam logic [3:0] CENTER_LEN  = 4'd5;
    localparam logic [3:0] DIGIT_LEN   = 4'd7;

    typedef struct {
        logic [8:0] modules;
        logic [3:0] count;
        logic       bad;
        logic       last;
    } segment_t;

    typedef struct {
        logic [95:0] data;
        bit          drain;   // hold off until every segment has come out
        bit          burst;   // no gaps or stalls while this code is in flight
    } code_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    ean13_barcode_module_encoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    code_item_t pending_codes[$];
    segment_t   segs_due[$];

    int  errors = 0;
    int  codes_sent = 0;
    int  bad_codes = 0;
    int  segs_seen = 0;
    int  drains = 0;

    bit  in_xfer = 0;      // set at the rising edge of an input transfer
    bit  out_xfer = 0;     // set at the rising edge of an output transfer
    bit  presenting = 0;
    bit  no_idle = 0;
    int  send_gap = 0;
    int  sink_stall = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Symbol encoder: the expected segments of one input transfer
    // ---------------------------------------------------------------
    function automatic logic [6:0] left_odd(input int d);
        case (d)
            0: return 7'h0D;  1: return 7'h19;  2: return 7'h13;  3: return 7'h3D;
            4: return 7'h23;  5: return 7'h31;  6: return 7'h2F;  7: return 7'h3B;
            8: return 7'h37;  default: return 7'h0B;
        endcase
    endfunction

    function automatic logic [6:0] left_even(input int d);
        case (d)
            0: return 7'h27;  1: return 7'h33;  2: return 7'h1B;  3: return 7'h21;
            4: return 7'h1D;  5: return 7'h39;  6: return 7'h05;  7: return 7'h11;
            8: return 7'h09;  default: return 7'h17;
        endcase
    endfunction

    function automatic logic [6:0] right_code(input int d);
        case (d)
            0: return 7'h72;  1: return 7'h66;  2: return 7'h6C;  3: return 7'h42;
            4: return 7'h5C;  5: return 7'h4E;  6: return 7'h50;  7: return 7'h44;
            8: return 7'h48;  default: return 7'h74;
        endcase
    endfunction

    // Which of characters 2..6 take the even code; bit 4 is character 2.
    function automatic logic [4:0] parity_of(input int d);
        case (d)
            0: return 5'h00;  1: return 5'h0B;  2: return 5'h0D;  3: return 5'h0E;
            4: return 5'h13;  5: return 5'h19;  6: return 5'h1C;  7: return 5'h15;
            8: return 5'h16;  default: return 5'h1A;
        endcase
    endfunction

    function automatic void push_seg(input logic [8:0] mods, input logic [3:0] cnt,
                                     input logic bad, input logic last);
        segment_t s;
        s.modules = mods;
        s.count   = cnt;
        s.bad     = bad;
        s.last    = last;
        segs_due.push_back(s);
    endfunction

    function automatic void encode_symbol(input logic [95:0] tdata);
        logic [47:0] hi;
        logic [47:0] lo;
        logic [7:0]  ch [12];
        int          dg [12];
        int          sum;
        int          chk;
        logic [4:0]  par;
        bit          bad;
        hi  = tdata[47:0];
        lo  = tdata[95:48];
        bad = 0;
        sum = 0;
        for (int i = 0; i < 6; i++) begin
            ch[i]     = hi[47 - 8 * i -: 8];
            ch[i + 6] = lo[47 - 8 * i -: 8];
        end
        for (int i = 0; i < 12; i++) begin
            if (ch[i] < 8'h30 || ch[i] > 8'h39)
                bad = 1;
            dg[i] = int'(ch[i]) - 'h30;
        end
        if (bad) begin
            // one flagged transfer, nothing drawn
            push_seg(9'd0, 4'd0, 1'b1, 1'b1);
            bad_codes++;
            return;
        end
        for (int i = 0; i < 12; i++)
            sum += (i % 2 == 1) ? 3 * dg[i] : dg[i];
        chk = (10 - sum % 10) % 10;
        par = parity_of(dg[0]);

        push_seg(9'd0, 4'(QUIET), 1'b0, 1'b0);
        push_seg(GUARD_MODS, GUARD_LEN, 1'b0, 1'b0);
        push_seg({2'b00, left_odd(dg[1])}, DIGIT_LEN, 1'b0, 1'b0);
        for (int i = 2; i < 7; i++)
            push_seg({2'b00, par[6 - i] ? left_even(dg[i]) : left_odd(dg[i])},
                     DIGIT_LEN, 1'b0, 1'b0);
        push_seg(CENTER_MODS, CENTER_LEN, 1'b0, 1'b0);
        for (int i = 7; i < 12; i++)
            push_seg({2'b00, right_code(dg[i])}, DIGIT_LEN, 1'b0, 1'b0);
        push_seg({2'b00, right_code(chk)}, DIGIT_LEN, 1'b0, 1'b0);
        push_seg(GUARD_MODS, GUARD_LEN, 1'b0, 1'b0);
        push_seg(9'd0, 4'(QUIET), 1'b0, 1'b1);
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // ---------------------------------------------------------------
    // Input side: rising-edge capture, falling-edge drive
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            encode_symbol(s_tdata);
            codes_sent++;
            in_xfer = 1;
        end
    end

    always @(negedge clk) begin
        code_item_t nxt;
        if (rst_n) begin
            if (in_xfer) begin
                in_xfer    = 0;
                presenting = 0;
                send_gap   = draw_wait();
            end
            if (!presenting) begin
                if (send_gap > 0) begin
                    send_gap--;
                end
                else if (pending_codes.size() > 0 &&
                         !(pending_codes[0].drain && segs_due.size() > 0)) begin
                    nxt = pending_codes.pop_front();
                    if (nxt.drain)
                        drains++;
                    no_idle    = nxt.burst;
                    s_tdata   <= nxt.data;
                    s_tvalid  <= 1'b1;
                    presenting = 1;
                end
            end
            if (!presenting)
                s_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Output side: check at the rising edge, stall at the falling edge
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        segment_t want;
        if (rst_n && m_tvalid && m_tready) begin
            out_xfer = 1;
            segs_seen++;
            if (segs_due.size() == 0) begin
                $display("%0t: unexpected segment tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else begin
                want = segs_due.pop_front();
                if (m_tdata[8:0] !== want.modules) begin
                    $display("%0t: modules expected %h actual %h",
                             $time, want.modules, m_tdata[8:0]);
                    errors++;
                end
                if (m_tdata[12:9] !== want.count) begin
                    $display("%0t: module_count expected %0d actual %0d",
                             $time, want.count, m_tdata[12:9]);
                    errors++;
                end
                if (m_tdata[15:13] !== 3'b000) begin
                    $display("%0t: tdata pad expected 0 actual %b", $time, m_tdata[15:13]);
                    errors++;
                end
                if (m_tuser !== want.bad) begin
                    $display("%0t: bad_input expected %b actual %b", $time, want.bad, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_segment expected %b actual %b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (out_xfer) begin
                out_xfer   = 0;
                sink_stall = draw_wait();
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    // Text holds character 0 in its top byte; the port wants characters 0..5
    // in the low half and 6..11 in the high half.
    function automatic logic [95:0] to_tdata(input logic [95:0] text);
        return {text[47:0], text[95:48]};
    endfunction

    function automatic void queue_code(input logic [95:0] text, input bit drain,
                                       input bit burst);
        code_item_t it;
        it.data  = to_tdata(text);
        it.drain = drain;
        it.burst = burst;
        pending_codes.push_back(it);
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: b = 8'h2F;                      // just below '0'
            1: b = 8'h3A;                      // just above '9'
            default: begin
                b = 8'($urandom_range(0, 255));
                while (b >= 8'h30 && b <= 8'h39)
                    b = 8'($urandom_range(0, 255));
            end
        endcase
        return b;
    endfunction

    function automatic logic [95:0] random_digits();
        logic [95:0] t;
        for (int i = 0; i < 12; i++)
            t[95 - 8 * i -: 8] = 8'h30 + 8'($urandom_range(0, 9));
        return t;
    endfunction

    initial begin
        logic [95:0] t;
        int          pos;
        int          burst_left;
        bit          burst;

        // Directed: all-zero and all-nine codes, every leading digit (each
        // parity pattern), a real-world code, non-digits at the edges of the
        // digit range and in the first, middle and last places, all-zero and
        // all-one bytes, and hold-offs until the output has drained.
        queue_code("000000000000", 0, 1);
        queue_code("999999999999", 0, 1);
        queue_code("400638133393", 0, 1);
        for (int d = 0; d < 10; d++)
            queue_code({8'h30 + 8'(d), "12345678905"}, 0, d < 3);
        queue_code({8'h2F, "00000000000"}, 1, 0);
        queue_code({"00000000000", 8'h3A}, 0, 0);
        queue_code({"12345", 8'h2F, "123456"}, 0, 0);
        queue_code({"123456", 8'h3A, "12345"}, 0, 0);
        queue_code({96{1'b0}}, 0, 0);
        queue_code({96{1'b1}}, 0, 1);
        queue_code("590123412345", 1, 0);
        queue_code("978020137962", 0, 0);

        // Random: mostly well-formed codes, with stray bad characters and
        // raw noise mixed in; some runs of codes go without gaps or stalls.
        burst_left = 0;
        burst      = 0;
        for (int n = 0; n < 90; n++) begin
            if (burst_left == 0) begin
                burst      = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(4, 12);
            end
            burst_left--;
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    t   = random_digits();
                    pos = $urandom_range(0, 11);
                    t[95 - 8 * pos -: 8] = non_digit();
                end
                3, 4: t = {$urandom, $urandom, $urandom};
                default: t = random_digits();
            endcase
            queue_code(t, (n == 55) || ($urandom_range(0, 24) == 0), burst);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_codes.size() > 0 || presenting)
            @(posedge clk);
        while (segs_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d codes (%0d rejected), %0d segments checked, %0d drain pauses",
                 codes_sent, bad_codes, segs_seen, drains);
        $display("Random gaps and stalls of 0..%0d cycles, with gap-free runs", MAX_WAIT);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
